>>> hw/rtl/sfht_pkg.sv
// Shared types and constants for the sequence frequency hash table.
// No dependencies.
`default_nettype none
package sfht_pkg;
	typedef enum logic [1:0] {
		REQ_GET = 2'd0,
		REQ_INC = 2'd1,
		REQ_DEC = 2'd2,
		REQ_SET = 2'd3
	} req_t;

	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_LIVE    = 2'd1;
	localparam logic [1:0] ST_DELETED = 2'd2;

	localparam logic [63:0] MIX_CONST = 64'h9E37_79B1_85EB_CA87;
	localparam int KEY_W   = 64;
	localparam int LEN_W   = 4;
	localparam int CNT_W   = 32;
	localparam int LIVE_W  = 9;
	// packed slot record: key, length, count
	localparam int REC_W   = KEY_W + LEN_W + CNT_W;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request, start hash
		logic hash_step;  // advance multiplier partial product
		logic set_home;   // probe index <= home slot
		logic rd;         // capture probe index of the status/record read
		logic eval;       // examine returned slot
		logic adv;        // step probe index
		logic commit;     // perform update
		logic clr_step;   // clearing pass write
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hash_done;
		logic hit;
		logic empty;
		logic last_probe;
		logic clr_done;
	} sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/sfht_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sfht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/sfht_ctrl.sv
// Controller state machine: reset clearing pass, hashing, probe walk, commit, result handshake.
// Depends on sfht_pkg.
`default_nettype none
module sfht_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sfht_pkg::sts_t sts,
	output sfht_pkg::cmd_t     cmd
);
	import sfht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HOME, S_READ, S_EVAL, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:  cmd.clr_step  = 1'b1;
			S_IDLE:   cmd.load      = in_valid;
			S_HASH:   cmd.hash_step = 1'b1;
			S_HOME:   cmd.set_home  = 1'b1;
			S_READ:   cmd.rd        = 1'b1;
			S_EVAL: begin
				cmd.eval = 1'b1;
				cmd.adv  = !(sts.hit || sts.empty || sts.last_probe);
			end
			S_COMMIT: cmd.commit    = 1'b1;
			S_OUT:    ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR:  if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE:   if (in_valid) state_q <= S_HASH;
				S_HASH:   if (sts.hash_done) state_q <= S_HOME;
				S_HOME:   state_q <= S_READ;
				S_READ:   state_q <= S_EVAL;
				S_EVAL: begin
					if (sts.hit || sts.empty || sts.last_probe) state_q <= S_COMMIT;
					else state_q <= S_READ;
				end
				S_COMMIT: state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sfht_dp.sv
// Datapath: key masking, multi-cycle hash, probe walk and slot update.
// Depends on sfht_pkg and sfht_ram.
`default_nettype none
module sfht_dp #(
	parameter int CAPACITY      = 256,
	parameter int MAX_KEY_BYTES = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sfht_pkg::cmd_t            cmd,
	output sfht_pkg::sts_t                 sts,
	input  wire logic [1:0]                req_type,
	input  wire logic [sfht_pkg::KEY_W-1:0] key_bytes,
	input  wire logic [sfht_pkg::LEN_W-1:0] key_length,
	input  wire logic [sfht_pkg::CNT_W-1:0] set_value,
	output logic [sfht_pkg::CNT_W-1:0]     count_out,
	output logic                           was_present,
	output logic                           table_full,
	output logic [sfht_pkg::LIVE_W-1:0]    live_entries
);
	import sfht_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	// hash takes the top HB bits, HB = max(1, ceil log2 CAPACITY) capped at 16
	localparam int HB0   = (IDX_W < 1) ? 1 : IDX_W;
	localparam int HB    = (HB0 > 16) ? 16 : HB0;
	localparam int PRB_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam int LIVE_CW = $clog2(CAPACITY + 1);
	// top bits are below 2*CAPACITY, so one compare and subtract wraps them
	localparam logic [HB:0] CAP_H = (HB+1)'(CAPACITY);

	// request registers
	logic [1:0]       req_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] setv_q;

	// hash: 64x64 low product in four 16-bit-by-64 partial products
	logic [KEY_W-1:0] prod_q;
	logic [1:0]       hcnt_q;
	logic             hash_done_q;
	logic [15:0]      kchunk;
	logic [79:0]      pp;
	logic [HB-1:0]    htop;
	logic [HB:0]      htop_x;
	logic [IDX_W-1:0] home;

	// probe
	logic [IDX_W-1:0] idx_q, rd_idx_q;
	logic [PRB_W-1:0] probes_q;
	logic             have_free_q, found_q;
	logic [IDX_W-1:0] free_q, hit_q;

	// stores
	logic [REC_W-1:0]  rec_rd;
	logic              rec_we;
	logic [IDX_W-1:0]  rec_waddr;
	logic [REC_W-1:0]  rec_wdata;
	logic [1:0]        st_rd;
	logic              st_we;
	logic [IDX_W-1:0]  st_waddr;
	logic [1:0]        st_wdata;
	logic [LIVE_CW-1:0] live_q;
	logic [IDX_W-1:0]  clr_q;
	logic              clr_done_q;

	logic [KEY_W-1:0] rk;
	logic [LEN_W-1:0] rl;
	logic [CNT_W-1:0] rc;
	logic             slot_match;

	// key masking at capture
	logic [LEN_W-1:0] len_c;
	logic [KEY_W-1:0] key_m;
	always_comb begin
		len_c = (key_length > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_length;
		for (int b = 0; b < 8; b++) begin
			key_m[b*8 +: 8] = (LEN_W'(b) < len_c) ? key_bytes[b*8 +: 8] : 8'h00;
		end
	end

	assign kchunk = key_q[hcnt_q*16 +: 16];
	assign pp     = 80'(kchunk) * 80'(MIX_CONST);
	assign htop   = prod_q[KEY_W-1 -: HB];
	assign htop_x = {1'b0, htop};
	assign home   = IDX_W'((htop_x >= CAP_H) ? htop_x - CAP_H : htop_x);

	assign {rk, rl, rc} = rec_rd;
	assign slot_match = (st_rd == ST_LIVE) && (rl == len_q) && (rk == key_q);

	assign sts.hash_done  = hash_done_q;
	assign sts.hit        = slot_match;
	assign sts.empty      = (st_rd == ST_EMPTY);
	assign sts.last_probe = (probes_q == PRB_W'(CAPACITY - 1));
	assign sts.clr_done   = clr_done_q;

	sfht_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_rec (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (idx_q),
		.rdata (rec_rd)
	);

	// commit decision
	logic             c_found;
	logic [CNT_W-1:0] c_count;
	logic             c_full, c_st_we, c_inc, c_dec;
	logic [1:0]       c_st;
	logic [IDX_W-1:0] c_addr;
	always_comb begin
		c_found = found_q;
		c_count = '0; c_full = 1'b0; c_st_we = 1'b0; c_st = ST_LIVE;
		c_addr = hit_q; c_inc = 1'b0; c_dec = 1'b0;
		rec_we = 1'b0; rec_waddr = hit_q; rec_wdata = {key_q, len_q, rc};
		if (cmd.commit) begin
			if (found_q) begin
				case (req_t'(req_q))
					REQ_GET: c_count = rc;
					REQ_INC: begin
						c_count = (rc == '1) ? rc : rc + CNT_W'(1);
						rec_we = 1'b1; rec_wdata = {key_q, len_q, c_count};
					end
					REQ_DEC: begin
						c_count = rc - CNT_W'(1);
						rec_we = 1'b1; rec_wdata = {key_q, len_q, c_count};
						if (c_count == '0) begin
							c_st_we = 1'b1; c_st = ST_DELETED; c_dec = 1'b1;
						end
					end
					default: begin
						if (setv_q == '0) begin
							c_st_we = 1'b1; c_st = ST_DELETED; c_dec = 1'b1;
						end else begin
							c_count = setv_q;
							rec_we = 1'b1; rec_wdata = {key_q, len_q, setv_q};
						end
					end
				endcase
			end else if (req_q == REQ_INC || (req_q == REQ_SET && setv_q != '0)) begin
				if (have_free_q) begin
					c_count = (req_q == REQ_INC) ? CNT_W'(1) : setv_q;
					rec_we = 1'b1; rec_waddr = free_q;
					rec_wdata = {key_q, len_q, c_count};
					c_st_we = 1'b1; c_st = ST_LIVE; c_addr = free_q; c_inc = 1'b1;
				end else begin
					c_full = 1'b1;
				end
			end
		end
	end

	// slot status store, cleared at reset by a sweep
	assign st_we    = cmd.clr_step || c_st_we;
	assign st_waddr = cmd.clr_step ? clr_q : c_addr;
	assign st_wdata = cmd.clr_step ? ST_EMPTY : c_st;

	sfht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_st (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (idx_q),
		.rdata (st_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_done_q <= 1'b0;
			live_q <= '0;
			hcnt_q <= '0;
			hash_done_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IDX_W'(1);
				clr_done_q <= (clr_q == IDX_LAST) || clr_done_q;
			end
			if (cmd.load) begin
				hcnt_q <= '0;
				hash_done_q <= 1'b0;
			end else if (cmd.hash_step) begin
				hcnt_q <= hcnt_q + 2'd1;
				hash_done_q <= (hcnt_q == 2'd3);
			end
			if (c_inc) live_q <= live_q + LIVE_CW'(1);
			else if (c_dec) live_q <= live_q - LIVE_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			key_q  <= key_m;
			len_q  <= len_c;
			setv_q <= set_value;
			prod_q <= '0;
		end
		if (cmd.hash_step && !hash_done_q) begin
			prod_q <= prod_q + (pp[KEY_W-1:0] << (hcnt_q * 16));
		end
		if (cmd.set_home) begin
			idx_q <= home;
			probes_q <= '0;
			have_free_q <= 1'b0;
			found_q <= 1'b0;
		end
		if (cmd.eval) begin
			if (slot_match) begin
				found_q <= 1'b1;
				hit_q <= rd_idx_q;
			end else if (st_rd != ST_LIVE && !have_free_q) begin
				have_free_q <= 1'b1;
				free_q <= rd_idx_q;
			end
		end
		if (cmd.adv) begin
			idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
			probes_q <= probes_q + PRB_W'(1);
		end
		if (cmd.commit) begin
			count_out   <= c_count;
			was_present <= c_found;
			table_full  <= c_full;
		end
	end

	assign live_entries = LIVE_W'(live_q);
endmodule
`default_nettype wire

>>> hw/rtl/sequence_frequency_hash_table_core.sv
// Sequence frequency hash table, open addressing with linear probing.
// Each request passes hash (four multiplier steps, one to settle), home slot,
// a read and an evaluate per probed slot, commit and result beat; the next
// request is accepted from the cycle after the result beat is taken.
// Reset: asynchronous, then a clearing pass marks all slots empty before the
// first beat is accepted.
`default_nettype none
module sequence_frequency_hash_table_core #(
	parameter int CAPACITY      = 256,
	parameter int MAX_KEY_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key_bytes,
	input  wire logic [3:0]  key_length,
	input  wire logic [31:0] set_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      count_out,
	output logic             was_present,
	output logic             table_full,
	output logic [8:0]       live_entries
);
	import sfht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller sequences one beat through hash, probe and commit
	sfht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath holds slot stores, hash and result registers
	sfht_dp #(.CAPACITY(CAPACITY), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.key_bytes    (key_bytes),
		.key_length   (key_length),
		.set_value    (set_value),
		.count_out    (count_out),
		.was_present  (was_present),
		.table_full   (table_full),
		.live_entries (live_entries)
	);
endmodule
`default_nettype wire
